/* rtl/heightmap_texel_shader_assert.svh */
// Assertion macros used by the shader back end (hts_back).
`ifndef HEIGHTMAP_TEXEL_SHADER_ASSERT_SVH
`define HEIGHTMAP_TEXEL_SHADER_ASSERT_SVH

// Same-cycle implication.
`define HTS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("shader assertion failed");

// Next-cycle implication.
`define HTS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("shader assertion failed");

`endif

/* rtl/hts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hts_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_SPACING = 3'd0,
        CFG_HEIGHT_SCALE = 3'd1,
        CFG_LIGHT_X      = 3'd2,
        CFG_LIGHT_Y      = 3'd3,
        CFG_LIGHT_Z      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] cell_spacing;
        logic [CFG_W-1:0] height_scale;
        logic [CFG_W-1:0] light_x;
        logic [CFG_W-1:0] light_y;
        logic [CFG_W-1:0] light_z;
    } cfg_t;

    localparam int HEIGHT_W   = 8;
    localparam int BAND_W     = 3;
    localparam int NUM_LIMITS = 5;
    localparam int SCALED_W   = 24;
    localparam logic [BAND_W-1:0] BAND_MAX = 3'd5;

    localparam logic [SCALED_W-1:0] BAND_LIMIT [NUM_LIMITS] = '{
        24'd10880, 24'd21760, 24'd32640, 24'd43520, 24'd54400
    };

    localparam int DELTA_W     = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int SQRT_STEPS = 17;
    localparam int D_W        = 34;
    localparam int ROOT_W     = 17;
    localparam int SQREM_W    = 19;
    localparam int NUM_W      = 35;
    localparam int DIV_STEPS  = 16;
    localparam int DVD_W      = 36;
    localparam int DREM_W     = 33;
    localparam int SHADE_W    = 16;
    localparam int TEXEL_W    = 32;

    typedef struct packed {
        logic signed [DELTA_W-1:0] db;
        logic signed [DELTA_W-1:0] dc;
        logic [BAND_W-1:0]         band;
    } q_item_t;

    typedef struct packed {
        logic               v;
        logic [BAND_W-1:0]  band;
        logic               zero;
        logic [NUM_W-1:0]   num;
        logic [D_W-1:0]     d;
        logic [ROOT_W-1:0]  root;
        logic [SQREM_W-1:0] rem;
    } sq_t;

    typedef struct packed {
        logic               v;
        logic [BAND_W-1:0]  band;
        logic               kill;
        logic               sat;
        logic [ROOT_W-1:0]  root;
        logic [DREM_W-1:0]  rmd;
        logic [SHADE_W-1:0] q;
    } dv_t;

    function automatic logic [BAND_W-1:0] band_of(input logic [SCALED_W-1:0] scaled);
        logic [BAND_W-1:0] b;
        b = '0;
        for (int i = 0; i < NUM_LIMITS; i++) begin
            if (scaled >= BAND_LIMIT[i]) begin
                b = BAND_W'(i + 1);
            end
        end
        return b;
    endfunction

    // R, G, B
    function automatic logic [23:0] band_rgb(input logic [BAND_W-1:0] band);
        logic [23:0] c;
        case (band)
            3'd0:    c = {8'd255, 8'd249, 8'd157};
            3'd1:    c = {8'd124, 8'd197, 8'd118};
            3'd2:    c = {8'd0,   8'd166, 8'd81};
            3'd3:    c = {8'd25,  8'd123, 8'd48};
            3'd4:    c = {8'd115, 8'd100, 8'd87};
            default: c = {8'd255, 8'd255, 8'd255};
        endcase
        return c;
    endfunction

    // one digit of the integer square root
    function automatic sq_t sqrt_step(input sq_t s, input int k);
        logic [SQREM_W-1:0] rem_sh;
        logic [SQREM_W-1:0] trial;
        sq_t o;
        o = s;
        rem_sh = {s.rem[SQREM_W-3:0], s.d[D_W-1-2*k -: 2]};
        trial  = {s.root, 2'b01};
        if (rem_sh >= trial) begin
            o.rem  = rem_sh - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = rem_sh;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit of the restoring divider
    function automatic dv_t div_step(input dv_t s, input int k);
        logic [DREM_W-1:0] cmp;
        dv_t o;
        o = s;
        cmp = DREM_W'(s.root) << (DIV_STEPS - 1 - k);
        if (s.rmd >= cmp) begin
            o.rmd = s.rmd - cmp;
            o.q[DIV_STEPS-1-k] = 1'b1;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

/* rtl/hts_height_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface hts_height_if;
    logic                         valid;
    logic                         ready;
    logic [hts_pkg::HEIGHT_W-1:0] height_here;
    logic [hts_pkg::HEIGHT_W-1:0] height_right;
    logic [hts_pkg::HEIGHT_W-1:0] height_below;

    modport source (output valid, height_here, height_right, height_below, input ready);
    modport sink   (input valid, height_here, height_right, height_below, output ready);
endinterface

`default_nettype wire

/* rtl/hts_texel_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface hts_texel_if;
    logic                        valid;
    logic                        ready;
    logic [hts_pkg::TEXEL_W-1:0] texel;
    logic [hts_pkg::BAND_W-1:0]  band;
    logic [hts_pkg::SHADE_W-1:0] shade;

    modport source (output valid, texel, band, shade, input ready);
    modport sink   (input valid, texel, band, shade, output ready);
endinterface

`default_nettype wire

/* rtl/hts_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module hts_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire hts_pkg::cfg_t    cfg,
    hts_height_if.sink            heights,
    input  wire logic             q_full,
    output logic                  f_valid,
    output hts_pkg::q_item_t      f_item
);

    logic                           f_v_reg;
    logic                           f_v_next;
    hts_pkg::q_item_t               f_item_reg;
    hts_pkg::q_item_t               f_item_next;
    logic [hts_pkg::SCALED_W-1:0]   scaled;
    logic                           xfer;

    assign heights.ready = !f_v_reg || !q_full;
    assign xfer          = heights.valid && heights.ready;
    assign f_valid       = f_v_reg;
    assign f_item        = f_item_reg;

    always_comb
    begin
        scaled = hts_pkg::SCALED_W'(heights.height_here)
               * hts_pkg::SCALED_W'(cfg.height_scale);
        f_item_next.band = hts_pkg::band_of(scaled);
        f_item_next.db   = $signed({1'b0, heights.height_right})
                         - $signed({1'b0, heights.height_here});
        f_item_next.dc   = $signed({1'b0, heights.height_below})
                         - $signed({1'b0, heights.height_here});
        if (xfer) begin
            f_v_next = 1'b1;
        end else if (!q_full) begin
            f_v_next = 1'b0;
        end else begin
            f_v_next = f_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            f_v_reg <= 1'b0;
        end else begin
            f_v_reg <= f_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer) begin
            f_item_reg <= f_item_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/hts_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module hts_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire hts_pkg::q_item_t  push_item,
    output logic                   full,
    input  wire logic              take,
    output logic                   head_valid,
    output hts_pkg::q_item_t       head_item
);

    hts_pkg::q_item_t              mem_reg [hts_pkg::QUEUE_DEPTH];
    logic [hts_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [hts_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [hts_pkg::QCNT_W-1:0]    count_reg;
    logic [hts_pkg::QCNT_W-1:0]    count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full       = count_reg == hts_pkg::QCNT_W'(hts_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = take && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/hts_back.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "heightmap_texel_shader_assert.svh"

module hts_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hts_pkg::cfg_t     cfg,
    input  wire logic              item_valid,
    input  wire hts_pkg::q_item_t  item,
    output logic                   take,
    hts_texel_if.source            texels
);

    logic en;

    // stage 0: queue head
    logic               s0_v_reg;
    hts_pkg::q_item_t   s0_item_reg;

    // stage 1: products
    logic                           s1_v_reg;
    logic [hts_pkg::BAND_W-1:0]     s1_band_reg;
    logic                           s1_zero_reg;
    logic signed [32:0]             s1_px_reg;
    logic signed [32:0]             s1_py_reg;
    logic signed [32:0]             s1_pz_reg;
    logic [16:0]                    s1_dsq_reg;
    logic [31:0]                    s1_ssq_reg;
    logic signed [32:0]             px_next;
    logic signed [32:0]             py_next;
    logic signed [32:0]             pz_next;
    logic [16:0]                    dsq_next;
    logic signed [hts_pkg::DELTA_W-1:0] ndb;

    // stage 2: dot product and squared length
    hts_pkg::sq_t   s2_reg;
    hts_pkg::sq_t   s2_next;

    hts_pkg::sq_t   sq_reg  [hts_pkg::SQRT_STEPS];
    hts_pkg::sq_t   sq_in   [hts_pkg::SQRT_STEPS];
    hts_pkg::sq_t   sq_next [hts_pkg::SQRT_STEPS];

    hts_pkg::dv_t   dv0_reg;
    hts_pkg::dv_t   dv0_next;
    hts_pkg::dv_t   dv_reg  [hts_pkg::DIV_STEPS];
    hts_pkg::dv_t   dv_in   [hts_pkg::DIV_STEPS];
    hts_pkg::dv_t   dv_next [hts_pkg::DIV_STEPS];
    hts_pkg::dv_t   dv_last;

    logic [hts_pkg::DVD_W-1:0]      dvd;
    logic signed [hts_pkg::NUM_W-1:0] num_s;

    logic                           sh_v_reg;
    logic [hts_pkg::BAND_W-1:0]     sh_band_reg;
    logic [hts_pkg::SHADE_W-1:0]    sh_shade_reg;
    logic [hts_pkg::SHADE_W-1:0]    shade_next;

    logic                           out_v_reg;
    logic [hts_pkg::TEXEL_W-1:0]    out_texel_reg;
    logic [hts_pkg::BAND_W-1:0]     out_band_reg;
    logic [hts_pkg::SHADE_W-1:0]    out_shade_reg;
    logic [hts_pkg::TEXEL_W-1:0]    texel_next;
    logic [23:0]                    rgb;

    function automatic logic [7:0] chan_scale(input logic [7:0] c,
                                              input logic [hts_pkg::SHADE_W-1:0] s);
        logic [23:0] p;
        p = 24'(c) * 24'(s) + 24'd32768;
        return p[23:16];
    endfunction

    assign en   = !out_v_reg || texels.ready;
    assign take = en;

    assign texels.valid = out_v_reg;
    assign texels.texel = out_texel_reg;
    assign texels.band  = out_band_reg;
    assign texels.shade = out_shade_reg;

    assign dv_last = dv_reg[hts_pkg::DIV_STEPS-1];

    always_comb
    begin
        ndb      = -s0_item_reg.db;
        px_next  = $signed({ndb, 8'b0}) * $signed(cfg.light_x);
        py_next  = $signed({1'b0, cfg.cell_spacing}) * $signed(cfg.light_y);
        pz_next  = $signed({s0_item_reg.dc, 8'b0}) * $signed(cfg.light_z);
        dsq_next = s0_item_reg.db * s0_item_reg.db + s0_item_reg.dc * s0_item_reg.dc;
    end

    always_comb
    begin
        s2_next.v    = s1_v_reg;
        s2_next.band = s1_band_reg;
        s2_next.zero = s1_zero_reg;
        s2_next.num  = hts_pkg::NUM_W'(s1_px_reg) + hts_pkg::NUM_W'(s1_py_reg)
                     + hts_pkg::NUM_W'(s1_pz_reg);
        s2_next.d    = hts_pkg::D_W'({s1_dsq_reg, 16'b0}) + hts_pkg::D_W'(s1_ssq_reg);
        s2_next.root = '0;
        s2_next.rem  = '0;
    end

    assign sq_in[0] = s2_reg;
    assign dv_in[0] = dv0_reg;

    for (genvar g = 1; g < hts_pkg::SQRT_STEPS; g++) begin : g_sq_chain
        assign sq_in[g] = sq_reg[g-1];
    end

    for (genvar g = 1; g < hts_pkg::DIV_STEPS; g++) begin : g_dv_chain
        assign dv_in[g] = dv_reg[g-1];
    end

    always_comb
    begin
        for (int k = 0; k < hts_pkg::SQRT_STEPS; k++) begin
            sq_next[k] = hts_pkg::sqrt_step(sq_in[k], k);
        end
        for (int k = 0; k < hts_pkg::DIV_STEPS; k++) begin
            dv_next[k] = hts_pkg::div_step(dv_in[k], k);
        end
    end

    // dividend 4*num + r/2, saturation and zero-result flags
    always_comb
    begin
        num_s         = $signed(sq_reg[hts_pkg::SQRT_STEPS-1].num);
        dvd           = hts_pkg::DVD_W'({sq_reg[hts_pkg::SQRT_STEPS-1].num[32:0], 2'b00})
                      + hts_pkg::DVD_W'(sq_reg[hts_pkg::SQRT_STEPS-1].root >> 1);
        dv0_next.v    = sq_reg[hts_pkg::SQRT_STEPS-1].v;
        dv0_next.band = sq_reg[hts_pkg::SQRT_STEPS-1].band;
        dv0_next.root = sq_reg[hts_pkg::SQRT_STEPS-1].root;
        dv0_next.kill = (num_s <= 0) || sq_reg[hts_pkg::SQRT_STEPS-1].zero
                      || (sq_reg[hts_pkg::SQRT_STEPS-1].root == '0);
        dv0_next.sat  = dvd >= hts_pkg::DVD_W'({sq_reg[hts_pkg::SQRT_STEPS-1].root, 16'b0});
        dv0_next.rmd  = dvd[hts_pkg::DREM_W-1:0];
        dv0_next.q    = '0;
    end

    always_comb
    begin
        if (dv_reg[hts_pkg::DIV_STEPS-1].kill) begin
            shade_next = '0;
        end else if (dv_reg[hts_pkg::DIV_STEPS-1].sat) begin
            shade_next = '1;
        end else begin
            shade_next = dv_reg[hts_pkg::DIV_STEPS-1].q;
        end
        rgb        = hts_pkg::band_rgb(sh_band_reg);
        texel_next = {chan_scale(8'd255, sh_shade_reg),
                      chan_scale(rgb[23:16], sh_shade_reg),
                      chan_scale(rgb[15:8], sh_shade_reg),
                      chan_scale(rgb[7:0], sh_shade_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_reg    <= '0;
            dv0_reg   <= '0;
            sh_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            for (int k = 0; k < hts_pkg::SQRT_STEPS; k++) begin
                sq_reg[k] <= '0;
            end
            for (int k = 0; k < hts_pkg::DIV_STEPS; k++) begin
                dv_reg[k] <= '0;
            end
        end else if (en) begin
            s0_v_reg  <= item_valid;
            s1_v_reg  <= s0_v_reg;
            s2_reg    <= s2_next;
            dv0_reg   <= dv0_next;
            sh_v_reg  <= dv_reg[hts_pkg::DIV_STEPS-1].v;
            out_v_reg <= sh_v_reg;
            for (int k = 0; k < hts_pkg::SQRT_STEPS; k++) begin
                sq_reg[k] <= sq_next[k];
            end
            for (int k = 0; k < hts_pkg::DIV_STEPS; k++) begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s0_item_reg   <= item;
            s1_band_reg   <= s0_item_reg.band;
            s1_zero_reg   <= cfg.cell_spacing == '0;
            s1_px_reg     <= px_next;
            s1_py_reg     <= py_next;
            s1_pz_reg     <= pz_next;
            s1_dsq_reg    <= dsq_next;
            s1_ssq_reg    <= 32'(cfg.cell_spacing) * 32'(cfg.cell_spacing);
            sh_band_reg   <= dv_reg[hts_pkg::DIV_STEPS-1].band;
            sh_shade_reg  <= shade_next;
            out_texel_reg <= texel_next;
            out_band_reg  <= sh_band_reg;
            out_shade_reg <= sh_shade_reg;
        end
    end

    `HTS_ASSERT_NXT(a_kill_dark, clk, rst_n, en && dv_last.v && dv_last.kill, sh_shade_reg == '0)
    `HTS_ASSERT_NXT(a_sat_full, clk, rst_n, en && dv_last.v && dv_last.sat && !dv_last.kill, sh_shade_reg == '1)
    `HTS_ASSERT_IMP(a_dark_texel, clk, rst_n, out_v_reg && out_shade_reg == '0, out_texel_reg == '0)
    `HTS_ASSERT_IMP(a_band_range, clk, rst_n, out_v_reg, out_band_reg <= hts_pkg::BAND_MAX)

endmodule

`default_nettype wire

/* rtl/heightmap_texel_shader.sv */
// Heightmap texel shader.
// heights: valid/ready channel, one transfer per texel carrying the raw
//   heights here, right and below. texels: valid/ready channel, one
//   transfer per input with packed ARGB texel, band and Q0.16 shade.
// Config: cfg_wr_en/cfg_index/cfg_data, to be written by the user only
//   while the block is idle (not enforced). One texel per cycle while
//   texels.ready is high. Shading pipeline: queue head, products, sums,
//   17-step square root, divider setup, 16-step divider, shade, output.
// A 4-entry queue separates the front stage (deltas, band) from the
//   shading pipeline. It holds while a texel waits with texels.ready low;
//   the queue keeps filling, and heights.ready drops once it is full.
// Reset clears all valid state and loads the default registers: spacing
//   1.0, height scale 1.0, light (0, 1, 0).
`timescale 1ns / 1ps
`default_nettype none

module heightmap_texel_shader (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [hts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hts_pkg::CFG_W-1:0]     cfg_data,
    hts_height_if.sink                         heights,
    hts_texel_if.source                        texels
);

    hts_pkg::cfg_t      cfg_reg;
    logic               q_full;
    logic               f_valid;
    hts_pkg::q_item_t   f_item;
    logic               head_valid;
    hts_pkg::q_item_t   head_item;
    logic               take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.cell_spacing <= 16'd256;
            cfg_reg.height_scale <= 16'd256;
            cfg_reg.light_x      <= 16'd0;
            cfg_reg.light_y      <= 16'd16384;
            cfg_reg.light_z      <= 16'd0;
        end else if (cfg_wr_en) begin
            case (hts_pkg::cfg_idx_t'(cfg_index))
                hts_pkg::CFG_CELL_SPACING: cfg_reg.cell_spacing <= cfg_data;
                hts_pkg::CFG_HEIGHT_SCALE: cfg_reg.height_scale <= cfg_data;
                hts_pkg::CFG_LIGHT_X:      cfg_reg.light_x      <= cfg_data;
                hts_pkg::CFG_LIGHT_Y:      cfg_reg.light_y      <= cfg_data;
                hts_pkg::CFG_LIGHT_Z:      cfg_reg.light_z      <= cfg_data;
                default: ;
            endcase
        end
    end

    hts_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .heights (heights),
        .q_full  (q_full),
        .f_valid (f_valid),
        .f_item  (f_item)
    );

    hts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_valid),
        .push_item  (f_item),
        .full       (q_full),
        .take       (take),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    hts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (head_valid),
        .item       (head_item),
        .take       (take),
        .texels     (texels)
    );

endmodule

`default_nettype wire
